[hdl/ltm_pkg.sv]
// Shared types, constants and character-class helpers for the log line token masker.
// No dependencies; ltm_match, ltm_emit and the top unit import this package.
package ltm_pkg;

	localparam int WINDOW_DEPTH_DEF = 64;
	// Lengths and positions inside the window; covers window depths up to 255.
	localparam int LEN_W = 8;

	localparam logic [2:0] K_CHAR = 3'd0;
	localparam logic [2:0] K_HEX  = 3'd1;
	localparam logic [2:0] K_UUID = 3'd2;
	localparam logic [2:0] K_IP   = 3'd3;
	localparam logic [2:0] K_PID  = 3'd4;
	localparam logic [2:0] K_NUM  = 3'd5;
	localparam logic [2:0] K_EOL  = 3'd6;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LSQ   = 8'h5b;
	localparam logic [7:0] CH_RSQ   = 8'h5d;
	localparam logic [7:0] CH_LRD   = 8'h28;
	localparam logic [7:0] CH_RRD   = 8'h29;

	localparam logic [3:0] UUID_LAST_LEN = 4'd12;

	typedef enum logic [2:0] {
		M_IDLE,
		M_HEX,
		M_NUM,
		M_PID_SQ,
		M_PID_RD
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FEED,
		S_POPEN,
		S_PNUM,
		S_PTOK,
		S_APPEND,
		S_SCAN,
		S_EVAL,
		S_DECIDE,
		S_POST,
		S_EOL,
		S_FLUSH
	} seq_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CHAR,
		OP_TOK,
		OP_EOL,
		OP_FLUSH
	} emit_op_t;

	typedef enum logic [1:0] {
		R_FAIL,
		R_WAIT,
		R_LONG,
		R_HIT
	} res_code_t;

	typedef struct packed {
		emit_op_t   op;
		logic [2:0] kind;
		logic [7:0] ch;
	} emit_req_t;

	typedef struct packed {
		res_code_t        code;
		logic [LEN_W-1:0] len;
	} mres_t;

	typedef struct packed {
		mres_t      hex;
		mres_t      uuid;
		mres_t      ip;
		mres_t      pid;
		mres_t      num;
		logic [7:0] c0;
		logic       all_done;
	} match_res_t;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_hexc(input logic [7:0] c);
		return is_dig(c) || ((c >= 8'h61) && (c <= 8'h66));
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0d));
	endfunction

	function automatic logic [3:0] uuid_glen(input logic [2:0] g);
		logic [3:0] r;
		r = (g == 3'd0) ? 4'd8 : ((g == 3'd4) ? UUID_LAST_LEN : 4'd4);
		return r;
	endfunction

endpackage

[hdl/ltm_if.sv]
// Handshake channels of the token masker: raw line bytes in, tokens out.
// Depends on nothing.
interface ltm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_line;
	modport source(output valid, ch, end_of_line, input ready);
	modport sink(input valid, ch, end_of_line, output ready);
endinterface

interface ltm_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] out_char;
	logic       last_of_run;
	modport source(output valid, kind, out_char, last_of_run, input ready);
	modport sink(input valid, kind, out_char, last_of_run, output ready);
endinterface

[hdl/ltm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ltm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/ltm_match.sv]
// Streaming matchers for HEX, UUID, IP, PID and NUM over one window pass.
// Uses ltm_pkg; fed one window byte per cycle by the sequencer.
module ltm_match import ltm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             vld,
	input  logic [7:0]       c,
	input  logic [LEN_W-1:0] pos,
	input  logic [LEN_W-1:0] fill,
	input  logic             cmpl,
	output match_res_t       res
);

	logic [1:0]       h_ph_q;
	logic             h_dn_q, h_hit_q;
	logic [LEN_W-1:0] h_len_q;
	logic [2:0]       u_g_q;
	logic [3:0]       u_n_q;
	logic             u_dn_q, u_hit_q;
	logic [LEN_W-1:0] u_len_q;
	logic [1:0]       i_g_q, i_n_q;
	logic             i_dw_q, i_dn_q, i_hit_q;
	logic [LEN_W-1:0] i_len_q;
	logic             p_ph_q, p_dn_q, p_hit_q;
	logic [7:0]       p_close_q;
	logic [LEN_W-1:0] p_len_q;
	logic             n_ph_q, n_dn_q, n_hit_q;
	logic [LEN_W-1:0] n_len_q;
	logic [7:0]       c0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_ph_q <= '0; h_dn_q <= 1'b0; h_hit_q <= 1'b0;
			u_g_q <= '0; u_n_q <= '0; u_dn_q <= 1'b0; u_hit_q <= 1'b0;
			i_g_q <= '0; i_n_q <= '0; i_dw_q <= 1'b0; i_dn_q <= 1'b0; i_hit_q <= 1'b0;
			p_ph_q <= 1'b0; p_dn_q <= 1'b0; p_hit_q <= 1'b0;
			n_ph_q <= 1'b0; n_dn_q <= 1'b0; n_hit_q <= 1'b0;
		end else if (clr) begin
			h_ph_q <= '0; h_dn_q <= 1'b0; h_hit_q <= 1'b0;
			u_g_q <= '0; u_n_q <= '0; u_dn_q <= 1'b0; u_hit_q <= 1'b0;
			i_g_q <= '0; i_n_q <= '0; i_dw_q <= 1'b0; i_dn_q <= 1'b0; i_hit_q <= 1'b0;
			p_ph_q <= 1'b0; p_dn_q <= 1'b0; p_hit_q <= 1'b0;
			n_ph_q <= 1'b0; n_dn_q <= 1'b0; n_hit_q <= 1'b0;
		end else if (vld) begin
			// hex: '0' 'x' then a run of hex digits
			if (!h_dn_q) begin
				case (h_ph_q)
					2'd0: if (c == CH_ZERO) h_ph_q <= 2'd1; else h_dn_q <= 1'b1;
					2'd1: if (c == CH_X) h_ph_q <= 2'd2; else h_dn_q <= 1'b1;
					2'd2: if (is_hexc(c)) h_ph_q <= 2'd3; else h_dn_q <= 1'b1;
					default: begin
						if (!is_hexc(c)) begin
							h_dn_q  <= 1'b1;
							h_hit_q <= 1'b1;
						end
					end
				endcase
			end
			// uuid: each group ends on the first non-hex byte
			if (!u_dn_q) begin
				if (is_hexc(c)) begin
					if (u_n_q == uuid_glen(u_g_q)) u_dn_q <= 1'b1;
					else u_n_q <= u_n_q + 4'd1;
				end else if (u_n_q != uuid_glen(u_g_q)) begin
					u_dn_q <= 1'b1;
				end else if (u_g_q == 3'd4) begin
					u_dn_q  <= 1'b1;
					u_hit_q <= 1'b1;
				end else if (c == CH_DASH) begin
					u_g_q <= u_g_q + 3'd1;
					u_n_q <= '0;
				end else begin
					u_dn_q <= 1'b1;
				end
			end
			// ip: four dotted groups, then reject a trailing dot plus digit
			if (!i_dn_q) begin
				if (i_dw_q) begin
					i_dn_q  <= 1'b1;
					i_hit_q <= !is_dig(c);
				end else if (is_dig(c)) begin
					if (i_n_q == 2'd3) i_dn_q <= 1'b1;
					else i_n_q <= i_n_q + 2'd1;
				end else if (i_n_q == 2'd0) begin
					i_dn_q <= 1'b1;
				end else if (i_g_q != 2'd3) begin
					if (c == CH_DOT) begin
						i_g_q <= i_g_q + 2'd1;
						i_n_q <= '0;
					end else begin
						i_dn_q <= 1'b1;
					end
				end else if (c == CH_DOT) begin
					i_dw_q <= 1'b1;
				end else begin
					i_dn_q  <= 1'b1;
					i_hit_q <= 1'b1;
				end
			end
			// pid: bracket, digits, matching close
			if (!p_dn_q) begin
				if (!p_ph_q) begin
					if (c == CH_LSQ || c == CH_LRD) p_ph_q <= 1'b1;
					else p_dn_q <= 1'b1;
				end else if (!is_dig(c)) begin
					p_dn_q  <= 1'b1;
					p_hit_q <= (pos != LEN_W'(1)) && (c == p_close_q);
				end
			end
			// num: plain digit run
			if (!n_dn_q) begin
				if (!n_ph_q) begin
					if (is_dig(c)) n_ph_q <= 1'b1;
					else n_dn_q <= 1'b1;
				end else if (!is_dig(c)) begin
					n_dn_q  <= 1'b1;
					n_hit_q <= 1'b1;
				end
			end
		end
	end

	// Payload side: lengths and the first byte need no reset.
	always_ff @(posedge clk) begin
		if (vld && !clr) begin
			if (pos == '0) begin
				c0_q      <= c;
				p_close_q <= (c == CH_LSQ) ? CH_RSQ : CH_RRD;
			end
			h_len_q <= pos;
			u_len_q <= pos;
			n_len_q <= pos;
			p_len_q <= pos + LEN_W'(1);
			if (!i_dn_q && !i_dw_q) begin
				i_len_q <= pos;
			end
		end
	end

	logic h_fz, u_fz, n_fz;

	// Freeze the length copies once a matcher has decided.
	assign h_fz = h_dn_q;
	assign u_fz = u_dn_q;
	assign n_fz = n_dn_q;

	logic [LEN_W-1:0] h_lk_q, u_lk_q, n_lk_q, p_lk_q;

	always_ff @(posedge clk) begin
		if (vld && !clr) begin
			if (!h_fz) h_lk_q <= pos;
			if (!u_fz) u_lk_q <= pos;
			if (!n_fz) n_lk_q <= pos;
			if (!p_dn_q) p_lk_q <= pos + LEN_W'(1);
		end
	end

	always_comb begin
		res = '0;
		res.c0 = c0_q;
		res.all_done = h_dn_q && u_dn_q && i_dn_q && p_dn_q && n_dn_q;

		if (h_dn_q) res.hex = h_hit_q ? '{R_HIT, h_lk_q} : '{R_FAIL, '0};
		else if (h_ph_q == 2'd3) res.hex = '{R_HIT, fill};
		else res.hex = cmpl ? '{R_FAIL, '0} : '{R_WAIT, '0};

		if (u_dn_q) res.uuid = u_hit_q ? '{R_HIT, u_lk_q} : '{R_FAIL, '0};
		else if (!cmpl) res.uuid = '{R_WAIT, '0};
		else if (u_g_q == 3'd4 && u_n_q == UUID_LAST_LEN) res.uuid = '{R_HIT, fill};
		else res.uuid = '{R_FAIL, '0};

		if (i_dn_q) res.ip = i_hit_q ? '{R_HIT, i_len_q} : '{R_FAIL, '0};
		else if (!cmpl) res.ip = '{R_WAIT, '0};
		else if (i_dw_q) res.ip = '{R_HIT, i_len_q};
		else if (i_g_q == 2'd3 && i_n_q != 2'd0) res.ip = '{R_HIT, fill};
		else res.ip = '{R_FAIL, '0};

		if (p_dn_q) res.pid = p_hit_q ? '{R_HIT, p_lk_q} : '{R_FAIL, '0};
		else if (cmpl) res.pid = '{R_FAIL, '0};
		else if (fill >= LEN_W'(10)) res.pid = '{R_LONG, '0};
		else res.pid = '{R_WAIT, '0};

		if (n_dn_q) res.num = n_hit_q ? '{R_HIT, n_lk_q} : '{R_FAIL, '0};
		else res.num = '{R_HIT, fill};
	end

	logic unused_lens;
	assign unused_lens = ^{h_len_q, u_len_q, n_len_q, p_len_q};

endmodule

[hdl/ltm_emit.sv]
// Result emitter: whitespace folding, one pending slot to mark the last result,
// and the output register. Uses ltm_pkg and ltm_out_if.
module ltm_emit import ltm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  emit_req_t   req,
	output logic        ack,
	ltm_out_if.source   token_out
);

	logic       pv_q, ov_q, psp_q, any_q;
	logic [2:0] pk_q, ok_q;
	logic [7:0] pc_q, oc_q;
	logic       ol_q;

	logic       pv_n, ov_n, psp_n, any_n, ol_n;
	logic [2:0] pk_n, ok_n;
	logic [7:0] pc_n, oc_n;
	logic       mv, pok, push, fl, vis;
	logic [2:0] push_k;
	logic [7:0] push_c;

	assign mv  = !ov_q || token_out.ready;
	assign pok = !pv_q || mv;

	always_comb begin
		pv_n = pv_q; ov_n = ov_q; psp_n = psp_q; any_n = any_q;
		pk_n = pk_q; pc_n = pc_q; ok_n = ok_q; oc_n = oc_q; ol_n = ol_q;
		ack = 1'b0; push = 1'b0; fl = 1'b0;
		push_k = K_CHAR; push_c = '0;
		vis = !(req.op == OP_CHAR && is_ws(req.ch));
		if (ov_q && token_out.ready) ov_n = 1'b0;

		case (req.op)
			OP_CHAR, OP_TOK: begin
				if (!vis) begin
					psp_n = 1'b1;
					ack = 1'b1;
				end else if (pok) begin
					psp_n = 1'b0;
					push = 1'b1;
					if (psp_q && any_q) begin
						// separator first; the token is not acknowledged yet and follows it
						push_k = K_CHAR;
						push_c = CH_SPACE;
					end else begin
						push_k = req.kind;
						push_c = (req.op == OP_CHAR) ? req.ch : 8'h00;
						any_n = 1'b1;
						ack = 1'b1;
					end
				end
			end
			OP_EOL: begin
				if (pok) begin
					push = 1'b1;
					push_k = K_EOL;
					psp_n = 1'b0;
					any_n = 1'b0;
					ack = 1'b1;
				end
			end
			OP_FLUSH: begin
				if (!pv_q) begin
					ack = 1'b1;
				end else if (mv) begin
					fl = 1'b1;
					ack = 1'b1;
				end
			end
			default: ;
		endcase

		if (push) begin
			if (pv_q) begin
				ov_n = 1'b1; ok_n = pk_q; oc_n = pc_q; ol_n = 1'b0;
			end
			pv_n = 1'b1; pk_n = push_k; pc_n = push_c;
		end
		if (fl) begin
			ov_n = 1'b1; ok_n = pk_q; oc_n = pc_q; ol_n = 1'b1;
			pv_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0; ov_q <= 1'b0; psp_q <= 1'b0; any_q <= 1'b0;
		end else begin
			pv_q <= pv_n; ov_q <= ov_n; psp_q <= psp_n; any_q <= any_n;
		end
	end

	always_ff @(posedge clk) begin
		pk_q <= pk_n; pc_q <= pc_n; ok_q <= ok_n; oc_q <= oc_n; ol_q <= ol_n;
	end

	assign token_out.valid       = ov_q;
	assign token_out.kind        = ok_q;
	assign token_out.out_char    = oc_q;
	assign token_out.last_of_run = ol_q;

endmodule

[hdl/log_line_token_masker_unit.sv]
// Log line token masker: one byte per transaction in, tokens out.
// A byte is taken only while idle and runs one window pass per decision; a pass makes
// one window RAM read per byte held in the window, so bytes held in the window
// are rescanned; end of line adds one more pass and the end token.
// A decided result passes through the pending slot and then the output register.
// Reset: asynchronous; window empty, no mode, no pending space. Window RAM is not cleared.
module log_line_token_masker_unit import ltm_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ltm_in_if.sink    line_in,
	ltm_out_if.source token_out
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int SW = AW + 1;

	seq_state_t     st_q, st_n;
	mode_t          mode_q, mode_n;
	logic [7:0]     run_q, run_n;
	logic [AW-1:0]  hd_q, hd_n;
	logic [FW-1:0]  fill_q, fill_n, idx_q, idx_n;
	logic           eol_q, eol_n, cmpl_q, cmpl_n;
	logic [7:0]     c_q, c_n, lc;

	logic           ram_we;
	logic [AW-1:0]  ram_wa, ram_ra;
	logic [7:0]     ram_rd;
	logic [FW-1:0]  rd_idx, dlen;
	logic           do_drop;

	logic           mclr, mvld;
	match_res_t     mres;
	emit_req_t      req;
	logic           ack;
	logic [LEN_W-1:0] fill8;
	logic [7:0]     po_open;
	logic           last_byte;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
	                                           input logic [FW-1:0] k);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(k);
		if (s >= SW'(WINDOW_DEPTH)) s = s - SW'(WINDOW_DEPTH);
		return s[AW-1:0];
	endfunction

	ltm_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_win (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(c_q), .raddr(ram_ra), .rdata(ram_rd)
	);

	ltm_match u_match (
		.clk(clk), .arst_n(arst_n), .clr(mclr), .vld(mvld), .c(ram_rd),
		.pos(LEN_W'(idx_q)), .fill(fill8), .cmpl(cmpl_q), .res(mres)
	);

	ltm_emit u_emit (
		.clk(clk), .arst_n(arst_n), .req(req), .ack(ack), .token_out(token_out)
	);

	assign fill8   = LEN_W'(fill_q);
	assign lc      = (line_in.ch >= 8'h41 && line_in.ch <= 8'h5a) ? line_in.ch + 8'd32
	                                                               : line_in.ch;
	assign po_open = (mode_q == M_PID_SQ) ? CH_LSQ : CH_LRD;
	assign rd_idx  = (st_q == S_EVAL) ? FW'(idx_q + 1'b1) : '0;
	assign ram_ra  = wrap_add(hd_q, rd_idx);
	assign ram_wa  = wrap_add(hd_q, fill_q);
	assign last_byte = (FW'(idx_q + 1'b1) == fill_q);
	assign line_in.ready = (st_q == S_IDLE);

	always_comb begin
		st_n = st_q; mode_n = mode_q; run_n = run_q; hd_n = hd_q; fill_n = fill_q;
		idx_n = idx_q; eol_n = eol_q; cmpl_n = cmpl_q; c_n = c_q;
		ram_we = 1'b0; mclr = 1'b0; mvld = 1'b0; do_drop = 1'b0; dlen = '0;
		req = '{op: OP_NONE, kind: K_CHAR, ch: 8'h00};

		case (st_q)
			S_IDLE: begin
				if (line_in.valid) begin
					c_n = lc;
					eol_n = line_in.end_of_line;
					cmpl_n = 1'b0;
					st_n = S_FEED;
				end
			end
			S_FEED: begin
				case (mode_q)
					M_HEX: begin
						if (is_hexc(c_q)) st_n = S_POST;
						else begin mode_n = M_IDLE; st_n = S_APPEND; end
					end
					M_NUM: begin
						if (is_dig(c_q)) st_n = S_POST;
						else begin mode_n = M_IDLE; st_n = S_APPEND; end
					end
					M_PID_SQ, M_PID_RD: begin
						if (is_dig(c_q)) begin
							if (run_q != 8'hff) run_n = run_q + 8'd1;
							st_n = S_POST;
						end else if ((mode_q == M_PID_SQ && c_q == CH_RSQ) ||
						             (mode_q == M_PID_RD && c_q == CH_RRD)) begin
							st_n = S_PTOK;
						end else begin
							st_n = S_POPEN;
						end
					end
					default: st_n = S_APPEND;
				endcase
			end
			S_PTOK: begin
				req = '{op: OP_TOK, kind: K_PID, ch: 8'h00};
				if (ack) begin mode_n = M_IDLE; run_n = '0; st_n = S_POST; end
			end
			S_POPEN: begin
				req = '{op: OP_CHAR, kind: K_CHAR, ch: po_open};
				if (ack) st_n = S_PNUM;
			end
			S_PNUM: begin
				req = '{op: OP_TOK, kind: K_NUM, ch: 8'h00};
				if (ack) begin
					mode_n = M_IDLE;
					run_n = '0;
					st_n = cmpl_q ? S_EOL : S_APPEND;
				end
			end
			S_APPEND: begin
				ram_we = 1'b1;
				fill_n = fill_q + 1'b1;
				st_n = S_SCAN;
			end
			S_SCAN: begin
				if (fill_q == '0) st_n = S_POST;
				else begin
					mclr = 1'b1;
					idx_n = '0;
					st_n = S_EVAL;
				end
			end
			S_EVAL: begin
				if (mres.all_done) st_n = S_DECIDE;
				else begin
					mvld = 1'b1;
					if (last_byte) st_n = S_DECIDE;
					else idx_n = FW'(idx_q + 1'b1);
				end
			end
			S_DECIDE: begin
				if (mres.hex.code == R_WAIT) st_n = S_POST;
				else if (mres.hex.code == R_HIT) begin
					req = '{op: OP_TOK, kind: K_HEX, ch: 8'h00};
					if (ack) begin
						if (mres.hex.len == fill8 && !cmpl_q) begin
							fill_n = '0; mode_n = M_HEX; st_n = S_POST;
						end else begin
							do_drop = 1'b1; dlen = FW'(mres.hex.len); st_n = S_SCAN;
						end
					end
				end else if (mres.uuid.code == R_WAIT) st_n = S_POST;
				else if (mres.uuid.code == R_HIT) begin
					req = '{op: OP_TOK, kind: K_UUID, ch: 8'h00};
					if (ack) begin do_drop = 1'b1; dlen = FW'(mres.uuid.len); st_n = S_SCAN; end
				end else if (mres.ip.code == R_WAIT) st_n = S_POST;
				else if (mres.ip.code == R_HIT) begin
					req = '{op: OP_TOK, kind: K_IP, ch: 8'h00};
					if (ack) begin do_drop = 1'b1; dlen = FW'(mres.ip.len); st_n = S_SCAN; end
				end else if (mres.pid.code == R_WAIT) st_n = S_POST;
				else if (mres.pid.code == R_LONG) begin
					// count the digits from here on instead of buffering them
					run_n = 8'(fill8 - LEN_W'(1));
					mode_n = (mres.c0 == CH_LSQ) ? M_PID_SQ : M_PID_RD;
					fill_n = '0;
					st_n = S_POST;
				end else if (mres.pid.code == R_HIT) begin
					req = '{op: OP_TOK, kind: K_PID, ch: 8'h00};
					if (ack) begin do_drop = 1'b1; dlen = FW'(mres.pid.len); st_n = S_SCAN; end
				end else if (mres.num.code == R_HIT) begin
					req = '{op: OP_TOK, kind: K_NUM, ch: 8'h00};
					if (ack) begin
						if (mres.num.len == fill8 && !cmpl_q) begin
							fill_n = '0; mode_n = M_NUM; st_n = S_POST;
						end else begin
							do_drop = 1'b1; dlen = FW'(mres.num.len); st_n = S_SCAN;
						end
					end
				end else begin
					req = '{op: OP_CHAR, kind: K_CHAR, ch: mres.c0};
					if (ack) begin do_drop = 1'b1; dlen = FW'(1); st_n = S_SCAN; end
				end
			end
			S_POST: begin
				if (eol_q && !cmpl_q) begin
					cmpl_n = 1'b1;
					st_n = S_SCAN;
				end else if (eol_q) begin
					st_n = (mode_q == M_PID_SQ || mode_q == M_PID_RD) ? S_POPEN : S_EOL;
				end else begin
					st_n = S_FLUSH;
				end
			end
			S_EOL: begin
				req = '{op: OP_EOL, kind: K_EOL, ch: 8'h00};
				if (ack) begin
					fill_n = '0; mode_n = M_IDLE; run_n = '0; st_n = S_FLUSH;
				end
			end
			S_FLUSH: begin
				req = '{op: OP_FLUSH, kind: K_CHAR, ch: 8'h00};
				if (ack) begin cmpl_n = 1'b0; st_n = S_IDLE; end
			end
			default: st_n = S_IDLE;
		endcase

		if (do_drop) begin
			hd_n = wrap_add(hd_q, dlen);
			fill_n = fill_q - dlen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; mode_q <= M_IDLE; run_q <= '0; hd_q <= '0; fill_q <= '0;
			idx_q <= '0; eol_q <= 1'b0; cmpl_q <= 1'b0;
		end else begin
			st_q <= st_n; mode_q <= mode_n; run_q <= run_n; hd_q <= hd_n; fill_q <= fill_n;
			idx_q <= idx_n; eol_q <= eol_n; cmpl_q <= cmpl_n;
		end
	end

	always_ff @(posedge clk) begin
		c_q <= c_n;
	end

endmodule
